/* design/weighted_b_matching_suitor_unit_defines.svh */
// Assertion macros shared by the suitor matching unit
`ifndef WEIGHTED_B_MATCHING_SUITOR_UNIT_DEFINES_SVH
`define WEIGHTED_B_MATCHING_SUITOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define WBS_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define WBS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wbs_pkg.sv */
// Types, constants and codes shared by the suitor matching unit
package wbs_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int VID_W        = 8;
    localparam int VCNT_W       = 9;
    localparam int MAX_EDGES    = 1024;
    localparam int EIDX_W       = 10;
    localparam int ECNT_W       = 11;
    localparam int MAX_BOUND    = 8;
    localparam int BND_W        = 4;
    localparam int SLOT_W       = 3;
    localparam int WEIGHT_W     = 16;
    localparam int SUM_W        = 27;
    localparam int TOTAL_W      = 26;
    localparam int SLOT_AW      = VID_W + SLOT_W;
    localparam int QUEUE_AW     = VID_W + 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BOUND = 2'd1,
        OP_RUN   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EDGE_DROP = 2'd1,
        ST_QUEUE_OVF = 2'd2
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [VID_W-1:0]    a;
        logic [VID_W-1:0]    b;
        logic [WEIGHT_W-1:0] w;
        logic [BND_W-1:0]    bnd;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] w;
        logic [VID_W-1:0]    b;
        logic [VID_W-1:0]    a;
    } edge_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] w;
        logic [VID_W-1:0]    id;
    } suitor_t;

    // per-vertex suitor summary: count and weakest suitor
    typedef struct packed {
        logic [BND_W-1:0]    sn;
        logic [WEIGHT_W-1:0] ww;
        logic [VID_W-1:0]    wid;
        logic [SLOT_W-1:0]   wslot;
    } vinfo_t;

    typedef enum logic [4:0] {
        ENG_IDLE, ENG_CLR, ENG_POP, ENG_POP_W, ENG_U_LD, ENG_PL, ENG_PL_W, ENG_CHK,
        ENG_SCAN, ENG_SCAN_E, ENG_SCAN_V, ENG_SEL, ENG_SEL_W, ENG_EV_W, ENG_DR_N,
        ENG_DR_R, ENG_DR_W, ENG_INS, ENG_WK_R, ENG_WK_W, ENG_SUM_V, ENG_SUM_N,
        ENG_SUM_K, ENG_SUM_X, ENG_SUM_E, ENG_SUM_EW, ENG_DONE
    } eng_state_t;

endpackage

/* design/wbs_front.sv */
// Front end: unpack input items, drop self loops, saturate bounds
module wbs_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wbs_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            fifo_ready,
    output wbs_pkg::cmd_chan_t              push
);

    wbs_pkg::cmd_t cmd;
    logic          keep;

    always_comb begin
        cmd.op  = wbs_pkg::op_t'(s_tuser);
        cmd.a   = s_tdata[7:0];
        cmd.b   = s_tdata[15:8];
        cmd.w   = s_tdata[31:16];
        cmd.bnd = (s_tdata[35:32] > wbs_pkg::BND_W'(wbs_pkg::MAX_BOUND))
                  ? wbs_pkg::BND_W'(wbs_pkg::MAX_BOUND) : s_tdata[35:32];
        // a self loop never enters the store
        keep    = !(cmd.op == wbs_pkg::OP_LOAD && cmd.a == cmd.b);
    end

    assign s_tready = fifo_ready;
    assign push     = '{valid: s_tvalid && fifo_ready && keep, cmd: cmd};

endmodule

/* design/wbs_cmd_fifo.sv */
// Short command queue between front end and matching engine
module wbs_cmd_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  wbs_pkg::cmd_chan_t  push,
    output logic                ready,
    input  logic                pop,
    output wbs_pkg::cmd_chan_t  head
);

    wbs_pkg::cmd_t                 buf_reg [wbs_pkg::FIFO_DEPTH];
    logic [wbs_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [wbs_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [wbs_pkg::FIFO_AW:0]     count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign ready      = count_reg != (wbs_pkg::FIFO_AW+1)'(wbs_pkg::FIFO_DEPTH);
    assign head       = '{valid: count_reg != '0, cmd: buf_reg[rd_ptr_reg]};
    assign do_push    = push.valid && ready;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) buf_reg[wr_ptr_reg] <= push.cmd;
    end

endmodule

/* design/wbs_engine.sv */
// Back end: edge store, bounds and the suitor matching sequencer
`include "weighted_b_matching_suitor_unit_defines.svh"
module wbs_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  wbs_pkg::cmd_chan_t               cmd_in,
    output logic                             cmd_pop,
    input  logic [wbs_pkg::VCNT_W-1:0]       vcount,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wbs_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser
);

    wbs_pkg::eng_state_t state_reg, state_next;

    // memories
    wbs_pkg::edge_t                edge_mem  [wbs_pkg::MAX_EDGES];
    logic [wbs_pkg::BND_W-1:0]     bound_mem [wbs_pkg::MAX_VERTICES];
    wbs_pkg::vinfo_t               vinfo_mem [wbs_pkg::MAX_VERTICES];
    logic [wbs_pkg::BND_W-1:0]     pn_mem    [wbs_pkg::MAX_VERTICES];
    logic [wbs_pkg::VID_W-1:0]     pt_mem    [wbs_pkg::MAX_VERTICES*wbs_pkg::MAX_BOUND];
    wbs_pkg::suitor_t              suit_mem  [wbs_pkg::MAX_VERTICES*wbs_pkg::MAX_BOUND];
    logic [wbs_pkg::VID_W-1:0]     q_mem     [2*wbs_pkg::MAX_VERTICES];

    logic                          e_we;
    logic [wbs_pkg::EIDX_W-1:0]    e_wa, e_ra;
    wbs_pkg::edge_t                e_wd, e_rd;
    logic                          b_we;
    logic [wbs_pkg::VID_W-1:0]     b_wa, b_ra;
    logic [wbs_pkg::BND_W-1:0]     b_wd, b_rd;
    logic                          bv_rd;
    logic                          vi_we;
    logic [wbs_pkg::VID_W-1:0]     vi_wa, vi_ra;
    wbs_pkg::vinfo_t               vi_wd, vi_rd;
    logic                          pn_we;
    logic [wbs_pkg::VID_W-1:0]     pn_wa, pn_ra;
    logic [wbs_pkg::BND_W-1:0]     pn_wd, pn_rd;
    logic                          pt_we;
    logic [wbs_pkg::SLOT_AW-1:0]   pt_wa, pt_ra;
    logic [wbs_pkg::VID_W-1:0]     pt_wd, pt_rd;
    logic                          su_we;
    logic [wbs_pkg::SLOT_AW-1:0]   su_wa, su_ra;
    wbs_pkg::suitor_t              su_wd, su_rd;
    logic                          q_we;
    logic [wbs_pkg::QUEUE_AW-1:0]  q_wa, q_ra;
    logic [wbs_pkg::VID_W-1:0]     q_wd, q_rd;

    // control registers
    logic [wbs_pkg::ECNT_W-1:0]    ecnt_reg;
    logic                          eovf_reg;
    logic                          bvld_reg [wbs_pkg::MAX_VERTICES];
    logic                          ovalid_reg;
    logic [wbs_pkg::TOTAL_W-1:0]   total_reg;
    wbs_pkg::status_t              status_reg;

    // datapath registers
    logic [wbs_pkg::VID_W-1:0]     cidx_reg;
    logic [wbs_pkg::VCNT_W-1:0]    work_n_reg, retry_n_reg;
    logic                          qsel_reg;
    logic                          run_ovf_reg;
    logic [wbs_pkg::VID_W-1:0]     u_reg, v_reg, bx_reg, y_reg;
    logic [wbs_pkg::VCNT_W-1:0]    sv_reg;
    logic [wbs_pkg::WEIGHT_W-1:0]  w_reg, bw_reg, bestw_reg;
    logic [wbs_pkg::VID_W-1:0]     bestid_reg;
    logic [wbs_pkg::SLOT_W-1:0]    bests_reg;
    logic [wbs_pkg::BND_W-1:0]     ubound_reg, upn_reg, ypn_reg, bsn_reg, k_reg, j_reg;
    logic [wbs_pkg::VID_W-1:0]     plist_reg [wbs_pkg::MAX_BOUND];
    logic [wbs_pkg::ECNT_W-1:0]    e_reg;
    logic                          found_reg;
    logic [wbs_pkg::SUM_W-1:0]     sum_reg;

    // derived
    logic [wbs_pkg::BND_W-1:0]     b_eff;
    logic [wbs_pkg::VID_W-1:0]     v_c;
    logic                          edge_ok, dup, elig, better, full_bx, sum_hit;
    logic [wbs_pkg::VCNT_W-1:0]    wn_m1;

    assign b_eff = bv_rd ? b_rd : '0;
    assign wn_m1 = work_n_reg - 1'b1;
    assign v_c   = (e_rd.a == u_reg) ? e_rd.b : e_rd.a;

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < wbs_pkg::MAX_BOUND; i++) begin
            if (wbs_pkg::BND_W'(i) < upn_reg && plist_reg[i] == v_c) dup = 1'b1;
        end
        edge_ok = {1'b0, e_rd.a} < vcount && {1'b0, e_rd.b} < vcount
                  && e_rd.a != e_rd.b && (e_rd.a == u_reg || e_rd.b == u_reg) && !dup;
        elig    = b_eff != '0 && (vi_rd.sn < b_eff || w_reg > vi_rd.ww
                  || (w_reg == vi_rd.ww && u_reg > vi_rd.wid));
        better  = !found_reg || w_reg > bw_reg || (w_reg == bw_reg && v_reg > bx_reg);
        full_bx = b_eff != '0 && vi_rd.sn >= b_eff;
        sum_hit = (e_rd.a == sv_reg[wbs_pkg::VID_W-1:0] && e_rd.b == v_reg)
                  || (e_rd.a == v_reg && e_rd.b == sv_reg[wbs_pkg::VID_W-1:0]);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wbs_pkg::ENG_IDLE:
                if (cmd_in.valid && cmd_in.cmd.op == wbs_pkg::OP_RUN)
                    state_next = wbs_pkg::ENG_CLR;
            wbs_pkg::ENG_CLR:
                if (cidx_reg == wbs_pkg::VID_W'(wbs_pkg::MAX_VERTICES-1))
                    state_next = wbs_pkg::ENG_POP;
            wbs_pkg::ENG_POP:
                if (work_n_reg != '0)       state_next = wbs_pkg::ENG_POP_W;
                else if (retry_n_reg == '0) state_next = wbs_pkg::ENG_SUM_V;
            wbs_pkg::ENG_POP_W:  state_next = wbs_pkg::ENG_U_LD;
            wbs_pkg::ENG_U_LD:   state_next = wbs_pkg::ENG_PL;
            wbs_pkg::ENG_PL:
                state_next = (k_reg == upn_reg) ? wbs_pkg::ENG_CHK : wbs_pkg::ENG_PL_W;
            wbs_pkg::ENG_PL_W:   state_next = wbs_pkg::ENG_PL;
            wbs_pkg::ENG_CHK:
                state_next = (upn_reg < ubound_reg) ? wbs_pkg::ENG_SCAN : wbs_pkg::ENG_POP;
            wbs_pkg::ENG_SCAN:
                if (e_reg != ecnt_reg) state_next = wbs_pkg::ENG_SCAN_E;
                else                   state_next = found_reg ? wbs_pkg::ENG_SEL
                                                              : wbs_pkg::ENG_POP;
            wbs_pkg::ENG_SCAN_E:
                state_next = edge_ok ? wbs_pkg::ENG_SCAN_V : wbs_pkg::ENG_SCAN;
            wbs_pkg::ENG_SCAN_V: state_next = wbs_pkg::ENG_SCAN;
            wbs_pkg::ENG_SEL:    state_next = wbs_pkg::ENG_SEL_W;
            wbs_pkg::ENG_SEL_W:
                state_next = full_bx ? wbs_pkg::ENG_EV_W : wbs_pkg::ENG_INS;
            wbs_pkg::ENG_EV_W:   state_next = wbs_pkg::ENG_DR_N;
            wbs_pkg::ENG_DR_N:   state_next = wbs_pkg::ENG_DR_R;
            wbs_pkg::ENG_DR_R:
                state_next = (k_reg == ypn_reg) ? wbs_pkg::ENG_INS : wbs_pkg::ENG_DR_W;
            wbs_pkg::ENG_DR_W:   state_next = wbs_pkg::ENG_DR_R;
            wbs_pkg::ENG_INS:    state_next = wbs_pkg::ENG_WK_R;
            wbs_pkg::ENG_WK_R:
                state_next = (k_reg == bsn_reg) ? wbs_pkg::ENG_CHK : wbs_pkg::ENG_WK_W;
            wbs_pkg::ENG_WK_W:   state_next = wbs_pkg::ENG_WK_R;
            wbs_pkg::ENG_SUM_V:
                state_next = (sv_reg == vcount) ? wbs_pkg::ENG_DONE : wbs_pkg::ENG_SUM_N;
            wbs_pkg::ENG_SUM_N:  state_next = wbs_pkg::ENG_SUM_K;
            wbs_pkg::ENG_SUM_K:
                state_next = (k_reg == ypn_reg) ? wbs_pkg::ENG_SUM_V : wbs_pkg::ENG_SUM_X;
            wbs_pkg::ENG_SUM_X:  state_next = wbs_pkg::ENG_SUM_E;
            wbs_pkg::ENG_SUM_E:
                state_next = (e_reg == ecnt_reg) ? wbs_pkg::ENG_SUM_K : wbs_pkg::ENG_SUM_EW;
            wbs_pkg::ENG_SUM_EW:
                state_next = sum_hit ? wbs_pkg::ENG_SUM_K : wbs_pkg::ENG_SUM_E;
            wbs_pkg::ENG_DONE:
                if (!ovalid_reg || m_tready) state_next = wbs_pkg::ENG_IDLE;
            default:             state_next = wbs_pkg::ENG_IDLE;
        endcase
    end

    // memory strobes and addresses
    always_comb begin
        cmd_pop = 1'b0;
        e_we  = 1'b0;
        e_wa  = ecnt_reg[wbs_pkg::EIDX_W-1:0];
        e_wd  = '{w: cmd_in.cmd.w, b: cmd_in.cmd.b, a: cmd_in.cmd.a};
        e_ra  = e_reg[wbs_pkg::EIDX_W-1:0];
        b_we  = 1'b0;
        b_wa  = cmd_in.cmd.a;
        b_wd  = cmd_in.cmd.bnd;
        b_ra  = v_c;
        vi_we = 1'b0;
        vi_wa = bx_reg;
        vi_wd = '{sn: bsn_reg, ww: bestw_reg, wid: bestid_reg, wslot: bests_reg};
        vi_ra = v_c;
        pn_we = 1'b0;
        pn_wa = u_reg;
        pn_wd = upn_reg + 1'b1;
        pn_ra = y_reg;
        pt_we = 1'b0;
        pt_wa = {u_reg, upn_reg[wbs_pkg::SLOT_W-1:0]};
        pt_wd = bx_reg;
        pt_ra = {u_reg, k_reg[wbs_pkg::SLOT_W-1:0]};
        su_we = 1'b0;
        su_wa = {bx_reg, bsn_reg[wbs_pkg::SLOT_W-1:0]};
        su_wd = '{w: bw_reg, id: u_reg};
        su_ra = {bx_reg, k_reg[wbs_pkg::SLOT_W-1:0]};
        q_we  = 1'b0;
        q_wa  = {~qsel_reg, retry_n_reg[wbs_pkg::VID_W-1:0]};
        q_wd  = y_reg;
        q_ra  = {qsel_reg, wn_m1[wbs_pkg::VID_W-1:0]};
        unique case (state_reg)
            wbs_pkg::ENG_IDLE: begin
                cmd_pop = cmd_in.valid;
                if (cmd_in.valid) begin
                    e_we = cmd_in.cmd.op == wbs_pkg::OP_LOAD
                           && ecnt_reg < wbs_pkg::ECNT_W'(wbs_pkg::MAX_EDGES);
                    b_we = cmd_in.cmd.op == wbs_pkg::OP_BOUND;
                end
            end
            wbs_pkg::ENG_CLR: begin
                vi_we = 1'b1;
                vi_wa = cidx_reg;
                vi_wd = '0;
                pn_we = 1'b1;
                pn_wa = cidx_reg;
                pn_wd = '0;
                q_we  = 1'b1;
                q_wa  = {1'b0, cidx_reg};
                q_wd  = cidx_reg;
            end
            wbs_pkg::ENG_POP_W: begin
                b_ra  = q_rd;
                pn_ra = q_rd;
            end
            wbs_pkg::ENG_SEL: begin
                b_ra  = bx_reg;
                vi_ra = bx_reg;
            end
            wbs_pkg::ENG_SEL_W: begin
                su_ra = {bx_reg, vi_rd.sn[wbs_pkg::SLOT_W-1:0] - 1'b1};
            end
            wbs_pkg::ENG_EV_W: begin
                // move the last suitor into the evicted slot
                su_we = 1'b1;
                su_wa = {bx_reg, k_reg[wbs_pkg::SLOT_W-1:0]};
                su_wd = su_rd;
            end
            wbs_pkg::ENG_DR_R: begin
                if (k_reg == ypn_reg) begin
                    pn_we = 1'b1;
                    pn_wa = y_reg;
                    pn_wd = j_reg;
                    q_we  = retry_n_reg < wbs_pkg::VCNT_W'(wbs_pkg::MAX_VERTICES);
                end else begin
                    pt_ra = {y_reg, k_reg[wbs_pkg::SLOT_W-1:0]};
                end
            end
            wbs_pkg::ENG_DR_W: begin
                if (pt_rd != bx_reg) begin
                    pt_we = 1'b1;
                    pt_wa = {y_reg, j_reg[wbs_pkg::SLOT_W-1:0]};
                    pt_wd = pt_rd;
                end
            end
            wbs_pkg::ENG_INS: begin
                su_we = 1'b1;
                pt_we = 1'b1;
                pn_we = 1'b1;
            end
            wbs_pkg::ENG_WK_R: vi_we = k_reg == bsn_reg;
            wbs_pkg::ENG_SUM_V: pn_ra = sv_reg[wbs_pkg::VID_W-1:0];
            wbs_pkg::ENG_SUM_K: pt_ra = {sv_reg[wbs_pkg::VID_W-1:0],
                                         k_reg[wbs_pkg::SLOT_W-1:0]};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (e_we) edge_mem[e_wa] <= e_wd;
        e_rd <= edge_mem[e_ra];
    end

    always_ff @(posedge aclk) begin
        if (b_we) bound_mem[b_wa] <= b_wd;
        b_rd  <= bound_mem[b_ra];
        bv_rd <= bvld_reg[b_ra];
    end

    always_ff @(posedge aclk) begin
        if (vi_we) vinfo_mem[vi_wa] <= vi_wd;
        vi_rd <= vinfo_mem[vi_ra];
    end

    always_ff @(posedge aclk) begin
        if (pn_we) pn_mem[pn_wa] <= pn_wd;
        pn_rd <= pn_mem[pn_ra];
    end

    always_ff @(posedge aclk) begin
        if (pt_we) pt_mem[pt_wa] <= pt_wd;
        pt_rd <= pt_mem[pt_ra];
    end

    always_ff @(posedge aclk) begin
        if (su_we) suit_mem[su_wa] <= su_wd;
        su_rd <= suit_mem[su_ra];
    end

    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd <= q_mem[q_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wbs_pkg::ENG_IDLE;
            ecnt_reg   <= '0;
            eovf_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < wbs_pkg::MAX_VERTICES; i++) bvld_reg[i] <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wbs_pkg::ENG_IDLE && cmd_in.valid) begin
                unique case (cmd_in.cmd.op)
                    wbs_pkg::OP_LOAD:
                        if (ecnt_reg < wbs_pkg::ECNT_W'(wbs_pkg::MAX_EDGES))
                            ecnt_reg <= ecnt_reg + 1'b1;
                        else
                            eovf_reg <= 1'b1;
                    wbs_pkg::OP_BOUND: bvld_reg[cmd_in.cmd.a] <= 1'b1;
                    wbs_pkg::OP_CLEAR: begin
                        ecnt_reg <= '0;
                        eovf_reg <= 1'b0;
                    end
                    wbs_pkg::OP_RUN: ;
                endcase
            end
            if (state_reg == wbs_pkg::ENG_DONE && (!ovalid_reg || m_tready))
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (state_reg == wbs_pkg::ENG_DONE && (!ovalid_reg || m_tready)) begin
            total_reg  <= sum_reg[wbs_pkg::SUM_W-1:1];
            status_reg <= run_ovf_reg ? wbs_pkg::ST_QUEUE_OVF
                        : (eovf_reg ? wbs_pkg::ST_EDGE_DROP : wbs_pkg::ST_OK);
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            wbs_pkg::ENG_IDLE: begin
                cidx_reg    <= '0;
                retry_n_reg <= '0;
                run_ovf_reg <= 1'b0;
                qsel_reg    <= 1'b0;
            end
            wbs_pkg::ENG_CLR: begin
                cidx_reg   <= cidx_reg + 1'b1;
                work_n_reg <= vcount;
            end
            wbs_pkg::ENG_POP: begin
                if (work_n_reg != '0) begin
                    work_n_reg <= wn_m1;
                end else if (retry_n_reg != '0) begin
                    // retry list becomes the work list
                    work_n_reg  <= retry_n_reg;
                    retry_n_reg <= '0;
                    qsel_reg    <= ~qsel_reg;
                end else begin
                    sv_reg  <= '0;
                    sum_reg <= '0;
                end
            end
            wbs_pkg::ENG_POP_W: u_reg <= q_rd;
            wbs_pkg::ENG_U_LD: begin
                ubound_reg <= b_eff;
                upn_reg    <= pn_rd;
                k_reg      <= '0;
            end
            wbs_pkg::ENG_PL_W: begin
                plist_reg[k_reg[wbs_pkg::SLOT_W-1:0]] <= pt_rd;
                k_reg <= k_reg + 1'b1;
            end
            wbs_pkg::ENG_CHK: begin
                found_reg <= 1'b0;
                e_reg     <= '0;
            end
            wbs_pkg::ENG_SCAN_E: begin
                v_reg <= v_c;
                w_reg <= e_rd.w;
                if (!edge_ok) e_reg <= e_reg + 1'b1;
            end
            wbs_pkg::ENG_SCAN_V: begin
                if (elig && better) begin
                    found_reg <= 1'b1;
                    bx_reg    <= v_reg;
                    bw_reg    <= w_reg;
                end
                e_reg <= e_reg + 1'b1;
            end
            wbs_pkg::ENG_SEL_W: begin
                bsn_reg <= full_bx ? vi_rd.sn - 1'b1 : vi_rd.sn;
                k_reg   <= {1'b0, vi_rd.wslot};
                y_reg   <= vi_rd.wid;
            end
            wbs_pkg::ENG_DR_N: begin
                ypn_reg <= pn_rd;
                k_reg   <= '0;
                j_reg   <= '0;
            end
            wbs_pkg::ENG_DR_R: begin
                if (k_reg == ypn_reg) begin
                    if (retry_n_reg < wbs_pkg::VCNT_W'(wbs_pkg::MAX_VERTICES))
                        retry_n_reg <= retry_n_reg + 1'b1;
                    else
                        run_ovf_reg <= 1'b1;
                end
            end
            wbs_pkg::ENG_DR_W: begin
                if (pt_rd != bx_reg) j_reg <= j_reg + 1'b1;
                k_reg <= k_reg + 1'b1;
            end
            wbs_pkg::ENG_INS: begin
                plist_reg[upn_reg[wbs_pkg::SLOT_W-1:0]] <= bx_reg;
                upn_reg <= upn_reg + 1'b1;
                bsn_reg <= bsn_reg + 1'b1;
                k_reg   <= '0;
            end
            wbs_pkg::ENG_WK_W: begin
                if (k_reg == '0 || su_rd.w < bestw_reg
                    || (su_rd.w == bestw_reg && su_rd.id < bestid_reg)) begin
                    bestw_reg  <= su_rd.w;
                    bestid_reg <= su_rd.id;
                    bests_reg  <= k_reg[wbs_pkg::SLOT_W-1:0];
                end
                k_reg <= k_reg + 1'b1;
            end
            wbs_pkg::ENG_SUM_N: begin
                ypn_reg <= pn_rd;
                k_reg   <= '0;
            end
            wbs_pkg::ENG_SUM_K: if (k_reg == ypn_reg) sv_reg <= sv_reg + 1'b1;
            wbs_pkg::ENG_SUM_X: begin
                v_reg <= pt_rd;
                e_reg <= '0;
            end
            wbs_pkg::ENG_SUM_E: if (e_reg == ecnt_reg) k_reg <= k_reg + 1'b1;
            wbs_pkg::ENG_SUM_EW: begin
                // first stored copy of the edge sets the weight
                if (sum_hit) begin
                    sum_reg <= sum_reg + wbs_pkg::SUM_W'(e_rd.w);
                    k_reg   <= k_reg + 1'b1;
                end else begin
                    e_reg <= e_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(wbs_pkg::OUT_DATA_W-wbs_pkg::TOTAL_W){1'b0}}, total_reg};
    assign m_tuser  = status_reg;

    `WBS_CHECK(a_ecnt_max, 1'b1, ecnt_reg <= wbs_pkg::ECNT_W'(wbs_pkg::MAX_EDGES), "edge count past store size")
    `WBS_CHECK(a_pop_valid, cmd_pop, cmd_in.valid && state_reg == wbs_pkg::ENG_IDLE, "pop of empty command queue")
    `WBS_CHECK(a_upn_bound, state_reg == wbs_pkg::ENG_CHK, upn_reg <= ubound_reg, "proposals exceed bound")
    `WBS_CHECK(a_retry_max, state_reg == wbs_pkg::ENG_POP, retry_n_reg <= wbs_pkg::VCNT_W'(wbs_pkg::MAX_VERTICES), "retry count past queue size")
    `WBS_CHECK_NEXT(a_done_out, state_reg == wbs_pkg::ENG_DONE && (!ovalid_reg || m_tready), m_tvalid && state_reg == wbs_pkg::ENG_IDLE, "finished run not presented")

endmodule

/* design/weighted_b_matching_suitor_unit.sv */
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser opcode; tdata vertices, weight, bound
// m_        out  m_tvalid/m_tready    tuser status; tdata total weight
// cfg_      in   cfg_valid/cfg_ready  vertex count, 9 bits
//
// Load, bound and clear items are taken one per cycle through a 4-entry queue
// while it has room. A run first clears the per-vertex state, then scans the
// store for every proposal attempt; an eviction and the weakest-suitor update
// each walk their list entry by entry. The total walks the store for each
// accepted proposal. Reset is synchronous on aresetn low; bounds read as zero
// until written. A held result stalls the engine.
module weighted_b_matching_suitor_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] first_vertex, [15:8] second_vertex, [31:16] edge_weight,
    // [35:32] bound_value, [39:36] zero
    input  logic [wbs_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [25:0] total_weight, [31:26] zero
    output logic [wbs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [1:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wbs_pkg::VCNT_W-1:0]      cfg_data
);

    logic [wbs_pkg::VCNT_W-1:0] vcount_reg;
    logic [wbs_pkg::VCNT_W-1:0] vcount_eff;
    wbs_pkg::cmd_chan_t         push;
    wbs_pkg::cmd_chan_t         head;
    logic                       fifo_ready;
    logic                       cmd_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= wbs_pkg::VCNT_W'(wbs_pkg::MAX_VERTICES);
        end else if (cfg_valid) begin
            vcount_reg <= cfg_data;
        end
    end

    // clamp to 1..MAX_VERTICES
    always_comb begin
        if (vcount_reg == '0)
            vcount_eff = wbs_pkg::VCNT_W'(1);
        else if (vcount_reg > wbs_pkg::VCNT_W'(wbs_pkg::MAX_VERTICES))
            vcount_eff = wbs_pkg::VCNT_W'(wbs_pkg::MAX_VERTICES);
        else
            vcount_eff = vcount_reg;
    end

    wbs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_ready (fifo_ready),
        .push       (push)
    );

    wbs_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .ready   (fifo_ready),
        .pop     (cmd_pop),
        .head    (head)
    );

    wbs_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_in   (head),
        .cmd_pop  (cmd_pop),
        .vcount   (vcount_eff),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* sim/tb_weighted_b_matching_suitor_unit.sv */
// Testbench for the suitor matching unit: directed table, random graphs, scoreboard
module tb_weighted_b_matching_suitor_unit;

    localparam int IDLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 2500;

    typedef struct {
        logic [wbs_pkg::TOTAL_W-1:0] total;
        wbs_pkg::status_t            st;
    } match_res_t;

    typedef struct {
        wbs_pkg::op_t op;
        int   a;
        int   b;
        int   w;
        int   bnd;
        bit   typed;
        int   etot;
        int   est;
    } stim_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [wbs_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [wbs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [wbs_pkg::VCNT_W-1:0]     cfg_data;

    weighted_b_matching_suitor_unit dut (.*);

    // matcher model state
    int e_a[wbs_pkg::MAX_EDGES];
    int e_b[wbs_pkg::MAX_EDGES];
    int e_w[wbs_pkg::MAX_EDGES];
    int n_edges;
    bit drop_seen;
    int v_bound[wbs_pkg::MAX_VERTICES];
    int v_count;
    int s_cnt[wbs_pkg::MAX_VERTICES];
    int s_wt[wbs_pkg::MAX_VERTICES][wbs_pkg::MAX_BOUND];
    int s_id[wbs_pkg::MAX_VERTICES][wbs_pkg::MAX_BOUND];
    int p_cnt[wbs_pkg::MAX_VERTICES];
    int p_to[wbs_pkg::MAX_VERTICES][wbs_pkg::MAX_BOUND];
    int retry_q[wbs_pkg::MAX_VERTICES];
    int retry_n;

    match_res_t pending_totals[$];
    int  mismatches;
    int  idle_cycles;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  rx_hold;
    stim_row_t dir_rows[15];

    function automatic int weakest(int v);
        int best;
        best = 0;
        for (int k = 1; k < s_cnt[v]; k++) begin
            if (s_wt[v][k] < s_wt[v][best] ||
                (s_wt[v][k] == s_wt[v][best] && s_id[v][k] < s_id[v][best]))
                best = k;
        end
        return best;
    endfunction

    function automatic bit is_full(int v);
        return v_bound[v] != 0 && s_cnt[v] >= v_bound[v];
    endfunction

    function automatic bit accepts(int v, int u, int w);
        int k;
        if (v_bound[v] == 0) return 0;
        if (!is_full(v)) return 1;
        k = weakest(v);
        return w > s_wt[v][k] || (w == s_wt[v][k] && u > s_id[v][k]);
    endfunction

    function automatic bit has_proposed(int u, int v);
        for (int k = 0; k < p_cnt[u]; k++)
            if (p_to[u][k] == v) return 1;
        return 0;
    endfunction

    function automatic int first_weight(int u, int v);
        for (int e = 0; e < n_edges; e++)
            if ((e_a[e] == u && e_b[e] == v) || (e_a[e] == v && e_b[e] == u))
                return e_w[e];
        return 0;
    endfunction

    function automatic void propose_from(int u, int n, ref bit ovf);
        bit found;
        int bx, bw, v, k, y, last, j;
        while (p_cnt[u] < v_bound[u]) begin
            found = 0;
            bx = 0;
            bw = 0;
            for (int e = 0; e < n_edges; e++) begin
                if (e_a[e] >= n || e_b[e] >= n || e_a[e] == e_b[e]) continue;
                if (e_a[e] == u) v = e_b[e];
                else if (e_b[e] == u) v = e_a[e];
                else continue;
                if (has_proposed(u, v) || !accepts(v, u, e_w[e])) continue;
                if (!found || e_w[e] > bw || (e_w[e] == bw && v > bx)) begin
                    found = 1;
                    bx = v;
                    bw = e_w[e];
                end
            end
            if (!found) break;
            if (is_full(bx)) begin
                k = weakest(bx);
                y = s_id[bx][k];
                last = s_cnt[bx] - 1;
                s_wt[bx][k] = s_wt[bx][last];
                s_id[bx][k] = s_id[bx][last];
                s_cnt[bx] = last;
                // drop the displaced suitor's proposal to bx
                j = 0;
                for (int q = 0; q < p_cnt[y]; q++)
                    if (p_to[y][q] != bx) begin
                        p_to[y][j] = p_to[y][q];
                        j++;
                    end
                p_cnt[y] = j;
                if (retry_n < wbs_pkg::MAX_VERTICES) begin
                    retry_q[retry_n] = y;
                    retry_n++;
                end else
                    ovf = 1;
            end
            s_wt[bx][s_cnt[bx]] = bw;
            s_id[bx][s_cnt[bx]] = u;
            s_cnt[bx]++;
            p_to[u][p_cnt[u]] = bx;
            p_cnt[u]++;
        end
    endfunction

    function automatic match_res_t run_matching();
        match_res_t r;
        int n, work_n;
        int work_q[wbs_pkg::MAX_VERTICES];
        bit ovf;
        longint sum;
        n = v_count;
        if (n < 1) n = 1;
        if (n > wbs_pkg::MAX_VERTICES) n = wbs_pkg::MAX_VERTICES;
        ovf = 0;
        sum = 0;
        for (int v = 0; v < wbs_pkg::MAX_VERTICES; v++) begin
            s_cnt[v] = 0;
            p_cnt[v] = 0;
        end
        retry_n = 0;
        work_n = 0;
        for (int v = 0; v < n; v++) begin
            work_q[work_n] = v;
            work_n++;
        end
        while (work_n > 0) begin
            while (work_n > 0) begin
                work_n--;
                propose_from(work_q[work_n], n, ovf);
            end
            for (int k = 0; k < retry_n; k++) work_q[k] = retry_q[k];
            work_n = retry_n;
            retry_n = 0;
        end
        for (int v = 0; v < n; v++)
            for (int k = 0; k < p_cnt[v]; k++)
                sum += first_weight(v, p_to[v][k]);
        r.total = wbs_pkg::TOTAL_W'(sum / 2);
        r.st = ovf ? wbs_pkg::ST_QUEUE_OVF
                   : (drop_seen ? wbs_pkg::ST_EDGE_DROP : wbs_pkg::ST_OK);
        return r;
    endfunction

    // apply one accepted item to the model; returns 1 when a result is due
    function automatic bit apply_item(wbs_pkg::op_t op, int a, int b, int w, int bnd,
                                      output match_res_t r);
        r.total = '0;
        r.st = wbs_pkg::ST_OK;
        case (op)
            wbs_pkg::OP_LOAD: begin
                if (a != b) begin
                    if (n_edges < wbs_pkg::MAX_EDGES) begin
                        e_a[n_edges] = a;
                        e_b[n_edges] = b;
                        e_w[n_edges] = w;
                        n_edges++;
                    end else
                        drop_seen = 1;
                end
            end
            wbs_pkg::OP_BOUND:
                v_bound[a] = (bnd > wbs_pkg::MAX_BOUND) ? wbs_pkg::MAX_BOUND : bnd;
            wbs_pkg::OP_CLEAR: begin
                n_edges = 0;
                drop_seen = 0;
            end
            default: begin
                r = run_matching();
                return 1;
            end
        endcase
        return 0;
    endfunction

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        aresetn = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
    end

    // watchdog on cycles with no handshake on any channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        match_res_t exp_r;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_gaps ? $urandom_range(0, 16) : 0;
            if (rx_hold) begin
                m_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 0;
            end else if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_totals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result total=%0d status=%0d",
                             m_tdata[wbs_pkg::TOTAL_W-1:0], m_tuser);
            end else begin
                exp_r = pending_totals.pop_front();
                if (m_tdata !== wbs_pkg::OUT_DATA_W'(exp_r.total) || m_tuser !== exp_r.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: total exp %0d got %0d, status exp %0d got %0d",
                                 exp_r.total, m_tdata, exp_r.st, m_tuser);
                end
            end
        end
    end

    task automatic send_item(wbs_pkg::op_t op, int a, int b, int w, int bnd,
                             bit typed = 0, int etot = 0, int est = 0);
        int gap;
        match_res_t r;
        gap = tx_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {4'b0, bnd[3:0], w[15:0], b[7:0], a[7:0]};
        do @(posedge aclk); while (!s_tready);
        if (apply_item(op, a & 8'hFF, b & 8'hFF, w & 16'hFFFF, bnd & 4'hF, r)) begin
            if (typed) begin
                r.total = etot;
                r.st = wbs_pkg::status_t'(est);
            end
            pending_totals = {pending_totals, r};
        end
    endtask

    // hold the input, let every result drain and the engine settle
    task automatic settle();
        s_tvalid <= 0;
        while (pending_totals.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_vertex_count(int val);
        settle();
        cfg_valid <= 1;
        cfg_data <= val[wbs_pkg::VCNT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        v_count = val & 9'h1FF;
    endtask

    task automatic random_graph();
        int n, span, k, a, b, w;
        case ($urandom_range(0, 7))
            0: n = wbs_pkg::MAX_VERTICES;
            1: n = 511;
            2: n = 0;
            default: n = $urandom_range(2, 12);
        endcase
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_gaps = $urandom_range(0, 2) != 0;
        write_vertex_count(n);
        send_item(wbs_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom, 0);
        span = (n >= 2 && n <= 12) ? n : 12;
        for (int v = 0; v < span; v++)
            send_item(wbs_pkg::OP_BOUND, v, $urandom_range(0, 255), $urandom,
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 4));
        k = $urandom_range(4, 24);
        for (int i = 0; i < k; i++) begin
            a = $urandom_range(0, span);
            b = $urandom_range(0, 7) == 0 ? a : $urandom_range(0, span);
            w = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
            // far edge: high vertex bits, outside the run for small vertex counts
            if ($urandom_range(0, 15) == 0) begin
                a = $urandom_range(128, 255);
                b = $urandom_range(128, 255);
            end
            send_item(wbs_pkg::OP_LOAD, a, b, w, $urandom_range(0, 15));
        end
        if ($urandom_range(0, 7) == 0)
            send_item(wbs_pkg::OP_BOUND, $urandom_range(128, 255), 0, 0,
                      $urandom_range(0, 15));
        send_item(wbs_pkg::OP_RUN, $urandom_range(0, 255), $urandom_range(0, 255), $urandom,
                  $urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) begin
            send_item(wbs_pkg::OP_LOAD, $urandom_range(0, span), $urandom_range(0, span),
                      $urandom, 0);
            send_item(wbs_pkg::OP_RUN, 0, 0, 0, 0);
        end
    endtask

    initial begin
        int sent;
        mismatches = 0;
        n_edges = 0;
        drop_seen = 0;
        v_count = wbs_pkg::MAX_VERTICES;
        for (int v = 0; v < wbs_pkg::MAX_VERTICES; v++) v_bound[v] = 0;
        tx_gaps = 1;
        rx_gaps = 1;
        rx_hold = 0;
        dir_rows = '{
            '{wbs_pkg::OP_RUN,   0,   0,     0,  0, 1, 0, wbs_pkg::ST_OK},
            '{wbs_pkg::OP_LOAD,  0,   1, 65535,  0, 0, 0, 0},
            '{wbs_pkg::OP_LOAD,  255, 254,   1, 15, 0, 0, 0},
            '{wbs_pkg::OP_LOAD,  7,   7,     9,  0, 0, 0, 0},
            '{wbs_pkg::OP_BOUND, 0,   0,     0, 15, 0, 0, 0},
            '{wbs_pkg::OP_BOUND, 1,   0,     0,  1, 0, 0, 0},
            '{wbs_pkg::OP_BOUND, 255, 255, 65535, 0, 0, 0, 0},
            '{wbs_pkg::OP_LOAD,  1,   2, 65535,  0, 0, 0, 0},
            '{wbs_pkg::OP_RUN,   0,   0,     0,  0, 0, 0, 0},
            '{wbs_pkg::OP_BOUND, 2,   0,     0,  8, 0, 0, 0},
            '{wbs_pkg::OP_LOAD,  0,   2,     0,  0, 0, 0, 0},
            '{wbs_pkg::OP_LOAD,  0,   1,     3,  0, 0, 0, 0},
            '{wbs_pkg::OP_RUN,   0,   0,     0,  0, 0, 0, 0},
            '{wbs_pkg::OP_CLEAR, 0,   0,     0,  0, 0, 0, 0},
            '{wbs_pkg::OP_RUN,   0,   0,     0,  0, 1, 0, wbs_pkg::ST_OK}
        };
        @(posedge aclk iff aresetn);
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w,
                      dir_rows[i].bnd, dir_rows[i].typed, dir_rows[i].etot, dir_rows[i].est);

        // vertex count extremes, including out of range values
        for (int i = 0; i < 4; i++) begin
            write_vertex_count(i == 0 ? 0 : i == 1 ? 1 : i == 2 ? 511 : 256);
            send_item(wbs_pkg::OP_LOAD, 0, 1, 5, 0);
            send_item(wbs_pkg::OP_RUN, 0, 0, 0, 0);
        end

        // fill the edge store past capacity; one vertex keeps the run short
        write_vertex_count(1);
        send_item(wbs_pkg::OP_CLEAR, 0, 0, 0, 0);
        tx_gaps = 0;
        for (int i = 0; i < wbs_pkg::MAX_EDGES + 6; i++)
            send_item(wbs_pkg::OP_LOAD, 2 + (i % 8), 3 + (i % 5) + 8, $urandom, 0);
        send_item(wbs_pkg::OP_RUN, 0, 0, 0, 0, 1, 0, wbs_pkg::ST_EDGE_DROP);
        send_item(wbs_pkg::OP_CLEAR, 0, 0, 0, 0);
        send_item(wbs_pkg::OP_RUN, 0, 0, 0, 0, 1, 0, wbs_pkg::ST_OK);

        // receiver holds off while runs keep arriving
        write_vertex_count(4);
        send_item(wbs_pkg::OP_LOAD, 0, 3, 11, 0);
        rx_hold = 1;
        for (int i = 0; i < 12; i++)
            send_item(wbs_pkg::OP_RUN, 0, 0, 0, 0);

        sent = 0;
        while (sent < 400) begin
            random_graph();
            sent += 30;
        end

        settle();
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
